// File: rtl/rtds_pkg.sv
// Package for the task ready/delay scheduler: types, opcodes, status codes.
// Used by every module of the block; no dependencies.
package rtds_pkg;

    localparam int NUM_TASKS_DEF = 16;
    localparam int MAX_TASKS     = 64;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_DELAY  = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SLOT  = 2'd1;
    localparam logic [1:0] ST_BAD_ID   = 2'd2;

    localparam logic [1:0] TS_DORMANT = 2'd0;
    localparam logic [1:0] TS_READY   = 2'd1;
    localparam logic [1:0] TS_DELAYED = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  task_id;
        logic [7:0]  task_prio;
        logic [31:0] delay_ticks;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] created_id;
        logic       ready_valid;
        logic [5:0] ready_head;
        logic [6:0] woken_count;
    } t_rsp;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // latch request, clear working status
        logic scan_start;// restart slot scan
        logic scan_step; // evaluate one slot
        logic apply_cmd; // apply create/delete/delay
        logic tick_inc;  // advance tick counter
        logic wake_best; // move best due task to ready
        logic out_load;  // capture result
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic [1:0] opcode;
        logic       scan_last;
        logic       found;
    } t_sts;

endpackage

// File: rtl/rtos_task_ready_delay_scheduler_unit.sv
// Top level of the task ready/delay scheduler.
// Depends on rtds_pkg, rtds_ctrl and rtds_datapath.
//
// One request is a command: create, delete, delay or tick. Each gives one
// result carrying the status and the ready queue head. The table is scanned
// one slot per cycle. Delete and delay apply the command and then scan for
// the ready queue head; create first scans for the lowest free slot; a tick
// advances the tick counter, then runs a full scan for the earliest due task
// for each task it wakes and one more that finds none, then the head scan.
// A new request is taken once the previous one is finished; the result waits
// in the output register and a stalled result holds the next one back.
module rtos_task_ready_delay_scheduler_unit #(
    parameter int NUM_TASKS = rtds_pkg::NUM_TASKS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  rtds_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output rtds_pkg::t_rsp o_rsp
);
    import rtds_pkg::*;

    t_cmd s_cmd;
    t_sts s_sts;

    rtds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd)
    );

    rtds_datapath #(.NUM_TASKS(NUM_TASKS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (s_cmd),
        .o_sts   (s_sts),
        .o_rsp   (o_rsp)
    );

endmodule

// File: rtl/rtds_datapath.sv
// Datapath of the task scheduler: task table, age matrices, tick counter,
// one-slot-per-cycle scan unit. Depends on rtds_pkg.
module rtds_datapath #(
    parameter int NUM_TASKS = rtds_pkg::NUM_TASKS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rtds_pkg::t_req i_req,
    input  rtds_pkg::t_cmd i_cmd,
    output rtds_pkg::t_sts o_sts,
    output rtds_pkg::t_rsp o_rsp
);
    import rtds_pkg::*;

    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    logic [1:0]           r_state [NUM_TASKS];
    logic [7:0]           r_prio  [NUM_TASKS];
    logic [31:0]          r_wake  [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_rage  [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_dage  [NUM_TASKS];
    logic [31:0]          r_tick;
    t_req                 r_req;
    t_rsp                 r_rsp;
    logic [IW-1:0]        r_idx;
    logic                 r_found;
    logic [IW-1:0]        r_best;
    logic [6:0]           r_woken;
    // wake scans run while r_wmode is set; a wake step that finds no due task clears it
    logic                 r_wmode;
    // free slot search of a create runs while r_cmode is set
    logic                 r_cmode;
    // working status, copied to the result register at out_load
    logic [1:0]           r_status;
    logic [5:0]           r_created;

    logic [IW-1:0] s_idx_id;
    logic          s_id_ok;
    logic          s_cand;
    logic          s_better;
    logic [31:0]   s_cur_wake;
    logic [31:0]   s_best_wake;

    assign s_id_ok  = ({2'b00, r_req.task_id} < 8'(NUM_TASKS));
    assign s_idx_id = r_req.task_id[IW-1:0];
    assign s_cur_wake  = r_wake[r_idx];
    assign s_best_wake = r_wake[r_best];

    // candidate test for the current slot depends on the scan purpose
    always_comb begin
        s_cand   = 1'b0;
        s_better = 1'b0;
        if (r_cmode) begin
            s_cand   = (r_state[r_idx] == TS_DORMANT);
            s_better = !r_found;
        end else if (r_wmode) begin
            s_cand   = (r_state[r_idx] == TS_DELAYED) && (s_cur_wake <= r_tick);
            s_better = !r_found || (s_cur_wake < s_best_wake)
                       || (s_cur_wake == s_best_wake && r_dage[r_idx][r_best]);
        end else begin
            s_cand   = (r_state[r_idx] == TS_READY);
            s_better = !r_found || (r_prio[r_idx] < r_prio[r_best])
                       || (r_prio[r_idx] == r_prio[r_best] && r_rage[r_idx][r_best]);
        end
    end

    assign o_sts.opcode    = r_req.opcode;
    assign o_sts.scan_last = (r_idx == IW'(NUM_TASKS - 1));
    assign o_sts.found     = r_found;
    assign o_rsp           = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_state[i] <= TS_DORMANT;
                r_prio[i]  <= 8'hFF;
                r_rage[i]  <= '0;
                r_dage[i]  <= '0;
            end
            r_tick    <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_best    <= '0;
            r_woken   <= '0;
            r_wmode   <= 1'b0;
            r_cmode   <= 1'b0;
            r_status  <= ST_OK;
            r_created <= '0;
            r_rsp     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_req     <= i_req;
                r_woken   <= '0;
                r_status  <= ST_OK;
                r_created <= '0;
                r_wmode   <= (i_req.opcode == OP_TICK);
                r_cmode   <= (i_req.opcode == OP_CREATE);
            end
            if (i_cmd.scan_start) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (s_cand && s_better) begin
                    r_found <= 1'b1;
                    r_best  <= r_idx;
                end
                if (r_idx != IW'(NUM_TASKS - 1)) r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.tick_inc) r_tick <= r_tick + 32'd1;
            if (i_cmd.wake_best) begin
                if (r_found) begin
                    r_state[r_best] <= TS_READY;
                    r_rage[r_best]  <= '0;
                    for (int j = 0; j < NUM_TASKS; j++)
                        if (j != int'(r_best)) r_rage[j][r_best] <= 1'b1;
                    r_woken <= r_woken + 7'd1;
                end else begin
                    r_wmode <= 1'b0;
                end
            end
            if (i_cmd.apply_cmd) begin
                r_cmode <= 1'b0;
                case (r_req.opcode)
                    OP_CREATE: begin
                        if (r_found) begin
                            r_state[r_best] <= TS_READY;
                            r_prio[r_best]  <= r_req.task_prio;
                            r_rage[r_best]  <= '0;
                            for (int j = 0; j < NUM_TASKS; j++)
                                if (j != int'(r_best)) r_rage[j][r_best] <= 1'b1;
                            r_created <= 6'(r_best);
                        end else begin
                            r_status <= ST_NO_SLOT;
                        end
                    end
                    OP_DELETE: begin
                        if (!s_id_ok) r_status <= ST_BAD_ID;
                        else begin
                            r_state[s_idx_id] <= TS_DORMANT;
                            r_prio[s_idx_id]  <= 8'hFF;
                        end
                    end
                    OP_DELAY: begin
                        if (!s_id_ok) r_status <= ST_BAD_ID;
                        else if (r_req.delay_ticks != 32'd0) begin
                            if (r_state[s_idx_id] != TS_READY) r_status <= ST_BAD_ID;
                            else begin
                                r_state[s_idx_id] <= TS_DELAYED;
                                r_wake[s_idx_id]  <= r_tick + r_req.delay_ticks;
                                r_dage[s_idx_id]  <= '0;
                                for (int j = 0; j < NUM_TASKS; j++)
                                    if (j != int'(s_idx_id)) r_dage[j][s_idx_id] <= 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_rsp.status      <= r_status;
                r_rsp.created_id  <= r_created;
                r_rsp.ready_valid <= r_found;
                r_rsp.ready_head  <= r_found ? 6'(r_best) : 6'd0;
                r_rsp.woken_count <= r_woken;
            end
        end
    end

endmodule

// File: rtl/rtds_ctrl.sv
// Controller of the task scheduler: sequences scans, updates and the
// request/result handshake. Depends on rtds_pkg.
module rtds_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  rtds_pkg::t_sts i_sts,
    output rtds_pkg::t_cmd o_cmd
);
    import rtds_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PRE   = 7'b0000010,  // create slot search / tick increment; delete and delay go on to S_APPLY
        S_APPLY = 7'b0000100,
        S_WSCAN = 7'b0001000,  // find earliest due delayed task
        S_WAKE  = 7'b0010000,
        S_HSCAN = 7'b0100000,  // find ready queue head
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_st, n_st;
    logic   r_ovalid, n_ovalid;

    assign o_valid = r_ovalid;
    assign o_stall = (r_st != S_IDLE);

    always_comb begin
        n_st     = r_st;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        case (r_st)
            S_IDLE: if (i_valid) begin
                o_cmd.load       = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_st = S_PRE;
            end
            S_PRE: begin
                case (i_sts.opcode)
                    OP_CREATE: begin
                        o_cmd.scan_step = 1'b1;
                        if (i_sts.scan_last) n_st = S_APPLY;
                    end
                    OP_TICK: begin
                        o_cmd.tick_inc   = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        n_st = S_WSCAN;
                    end
                    default: n_st = S_APPLY;
                endcase
            end
            S_APPLY: begin
                o_cmd.apply_cmd  = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_st = S_HSCAN;
            end
            S_WSCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_st = S_WAKE;
            end
            S_WAKE: begin
                o_cmd.wake_best  = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_st = i_sts.found ? S_WSCAN : S_HSCAN;
            end
            S_HSCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_st = S_OUT;
            end
            S_OUT: if (!r_ovalid) begin
                o_cmd.out_load = 1'b1;
                n_ovalid = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// File: sim/testbench.sv
// Testbench for rtos_task_ready_delay_scheduler_unit: directed and random commands,
// checked against an in-bench scheduler predictor. Depends on rtds_pkg and the RTL.
module testbench;
    import rtds_pkg::*;

    localparam int NT = NUM_TASKS_DEF;
    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_req i_req = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_rsp o_rsp;

    rtos_task_ready_delay_scheduler_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [1:0]    sch_state [NT];
    logic [7:0]    sch_prio [NT];
    logic [31:0]   sch_wake [NT];
    logic [NT-1:0] rdy_age [NT];
    logic [NT-1:0] dly_age [NT];
    logic [31:0]   sch_tick;

    t_rsp rsp_queue[$];
    int   mismatches = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   quiet_cycles = 0;

    function automatic void sched_reset();
        for (int i = 0; i < NT; i++) begin
            sch_state[i] = TS_DORMANT;
            sch_prio[i] = 8'hFF;
            sch_wake[i] = '0;
            rdy_age[i] = '0;
            dly_age[i] = '0;
        end
        sch_tick = '0;
    endfunction

    function automatic t_rsp sched_apply(t_req r);
        t_rsp o;
        int best;
        o = '0;
        case (r.opcode)
            OP_CREATE: begin
                o.status = ST_NO_SLOT;
                for (int i = 0; i < NT; i++) begin
                    if (o.status == ST_NO_SLOT && sch_state[i] == TS_DORMANT) begin
                        sch_prio[i] = r.task_prio;
                        sch_state[i] = TS_READY;
                        rdy_age[i] = '0;
                        for (int j = 0; j < NT; j++) if (j != i) rdy_age[j][i] = 1'b1;
                        o.created_id = 6'(i);
                        o.status = ST_OK;
                    end
                end
            end
            OP_DELETE: begin
                if (r.task_id >= NT) o.status = ST_BAD_ID;
                else begin
                    sch_state[r.task_id] = TS_DORMANT;
                    sch_prio[r.task_id] = 8'hFF;
                end
            end
            OP_DELAY: begin
                if (r.task_id >= NT) o.status = ST_BAD_ID;
                else if (r.delay_ticks != 0) begin
                    if (sch_state[r.task_id] != TS_READY) o.status = ST_BAD_ID;
                    else begin
                        sch_state[r.task_id] = TS_DELAYED;
                        sch_wake[r.task_id] = sch_tick + r.delay_ticks;
                        dly_age[r.task_id] = '0;
                        for (int j = 0; j < NT; j++)
                            if (j != r.task_id) dly_age[j][r.task_id] = 1'b1;
                    end
                end
            end
            default: begin
                sch_tick = sch_tick + 32'd1;
                forever begin
                    best = -1;
                    for (int i = 0; i < NT; i++) begin
                        if (sch_state[i] == TS_DELAYED && sch_wake[i] <= sch_tick) begin
                            if (best < 0 || sch_wake[i] < sch_wake[best] ||
                                (sch_wake[i] == sch_wake[best] && dly_age[i][best]))
                                best = i;
                        end
                    end
                    if (best < 0) break;
                    sch_state[best] = TS_READY;
                    rdy_age[best] = '0;
                    for (int j = 0; j < NT; j++) if (j != best) rdy_age[j][best] = 1'b1;
                    o.woken_count = o.woken_count + 7'd1;
                end
            end
        endcase
        best = -1;
        for (int i = 0; i < NT; i++) begin
            if (sch_state[i] == TS_READY) begin
                if (best < 0 || sch_prio[i] < sch_prio[best] ||
                    (sch_prio[i] == sch_prio[best] && rdy_age[i][best]))
                    best = i;
            end
        end
        if (best >= 0) begin
            o.ready_valid = 1'b1;
            o.ready_head = 6'(best);
        end
        return o;
    endfunction

    // valid stays high between back-to-back requests; it drops only for idle gaps and in drain
    task automatic send_cmd(input logic [1:0] op, input logic [5:0] id,
                            input logic [7:0] prio, input logic [31:0] ticks);
        t_req r;
        r.opcode = op;
        r.task_id = id;
        r.task_prio = prio;
        r.delay_ticks = ticks;
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        rsp_queue.push_back(sched_apply(r));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (rsp_queue.size() != 0) @(posedge i_clk);
    endtask

    // random id, mostly valid slots
    function automatic logic [5:0] pick_id();
        if ($urandom_range(9) == 0) return 6'($urandom_range(63));
        return 6'($urandom_range(NT - 1));
    endfunction

    function automatic logic [31:0] pick_ticks();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return $urandom();
            2: return 32'hFFFF_FFFF - 32'($urandom_range(3));
            default: return 32'($urandom_range(1, 6));
        endcase
    endfunction

    // response checker and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (rsp_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", o_rsp);
                end else begin
                    t_rsp e;
                    e = rsp_queue.pop_front();
                    if (e.status !== o_rsp.status || e.created_id !== o_rsp.created_id ||
                        e.ready_valid !== o_rsp.ready_valid ||
                        e.ready_head !== o_rsp.ready_head ||
                        e.woken_count !== o_rsp.woken_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p actual %p", e, o_rsp);
                    end
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("** rtos_task_ready_delay_scheduler_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_cmd(OP_TICK, 6'd0, 8'd0, 32'd0);
        send_cmd(OP_CREATE, 6'd0, 8'hFF, 32'd0);    // lowest urgency
        send_cmd(OP_CREATE, 6'd63, 8'h00, 32'd0);
        send_cmd(OP_CREATE, 6'd0, 8'h00, 32'd0);    // same prio, FIFO
        send_cmd(OP_DELAY, 6'd1, 8'd0, 32'd0);      // zero ticks
        send_cmd(OP_DELAY, 6'd63, 8'd0, 32'd5);     // bad id
        send_cmd(OP_DELAY, 6'd9, 8'd0, 32'd5);      // dormant slot
        send_cmd(OP_DELAY, 6'd1, 8'd0, 32'd2);
        send_cmd(OP_DELAY, 6'd2, 8'd0, 32'd2);      // same wake tick
        send_cmd(OP_DELAY, 6'd0, 8'd0, 32'hFFFF_FFFF); // wraps, due next tick
        send_cmd(OP_TICK, 6'd0, 8'd0, 32'd0);
        send_cmd(OP_TICK, 6'd0, 8'd0, 32'd0);
        send_cmd(OP_DELETE, 6'd16, 8'd0, 32'd0);
        send_cmd(OP_DELETE, 6'd12, 8'd0, 32'd0);    // dormant slot
        send_cmd(OP_DELETE, 6'd0, 8'd0, 32'd0);
        for (int i = 0; i < NT + 1; i++)
            send_cmd(OP_CREATE, 6'd0, 8'($urandom_range(3)), 32'd0);
        drain();
    endtask

    task automatic test_random(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 25) send_cmd(OP_CREATE, 6'($urandom()), 8'($urandom()), $urandom());
            else if (k < 42) send_cmd(OP_DELETE, pick_id(), 8'($urandom()), $urandom());
            else if (k < 72) send_cmd(OP_DELAY, pick_id(), 8'($urandom()), pick_ticks());
            else send_cmd(OP_TICK, 6'($urandom()), 8'($urandom()), $urandom());
        end
    endtask

    task automatic test_phases();
        idle_pct = 0;  stall_pct = 0;  test_random(250);
        idle_pct = 45; stall_pct = 0;  test_random(250);
        drain();       // sender holds off until all results are back
        idle_pct = 0;  stall_pct = 45; test_random(250);
        idle_pct = 8;  stall_pct = 8;  test_random(275);
        idle_pct = 0;  stall_pct = 0;
    endtask

    initial begin
        sched_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_phases();
        drain();
        repeat (4 * NT * NT) @(posedge i_clk);
        if (mismatches == 0 && rsp_queue.size() == 0)
            $display("** rtos_task_ready_delay_scheduler_unit: PASSED **");
        else
            $display("** rtos_task_ready_delay_scheduler_unit: FAILED **");
        $finish;
    end
endmodule
